>>> rtl/assert_macros.svh
// Assertion macros shared by the transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    `ASSERT_PROP(lbl, (ante) |-> (cons), msg)

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    `ASSERT_PROP(lbl, (ante) |=> (cons), msg)

`endif

>>> rtl/mvt_pkg.sv
// Shared widths, types and reset values of the matrix-vector transform.
`timescale 1ns / 1ps

package mvt_pkg;

    // Data widths (Q16.16 data and coefficients, Q32.32 products and sums)
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM2_W   = PROD_W + 1;
    localparam int SUM4_W   = PROD_W + 2;

    // Matrix shape
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 4;

    // Register file: two entries per 64-bit register
    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 2 * DATA_W;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int ADDR_LSB   = $clog2(REG_W / 8);
    localparam int APB_ADDR_W = REG_IDX_W + ADDR_LSB;

    // Pipeline: products, pair sums, row sum, shift and saturate
    localparam int NUM_STAGES = 4;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Identity matrix at reset
    localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic signed [DATA_W-1:0] coef_t;

    // Per-stage load enables, shared by every row lane
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

>>> rtl/mat4_vector_transform.sv
// Top level of the 4x4 matrix-vector transform. It multiplies each Q16.16
// vector beat (x_in..w_in) by the matrix in eight 64-bit APB registers at
// byte offsets 0x00..0x38 (row r uses offsets 16*r and 16*r+8, even column
// in the low word); reset loads the identity. Each output component is the
// exact sum of four 64-bit products, shifted right by 16 with floor rounding
// and clamped to 32 bits; overflow flags a clamp in any component. The block
// takes one vector per clock while in_ready is high and passes it through the
// stages in order: stage one holds the sixteen 32x32 multipliers, then the
// pair adds, the row sum, and the shift and clamp.
// Each stage carries its own valid bit, so a stall at the output only backs
// up stages that are full, and in_ready stays high while any stage is empty.
// Write the matrix only while no beat is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mat4_vector_transform
    import mvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]      pwdata,
    output logic [REG_W-1:0]      prdata,
    output logic                  pready,
    // Input vectors
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [DATA_W-1:0] x_in,
    input  logic signed [DATA_W-1:0] y_in,
    input  logic signed [DATA_W-1:0] z_in,
    input  logic signed [DATA_W-1:0] w_in,
    // Transformed vectors
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [DATA_W-1:0] x_out,
    output logic signed [DATA_W-1:0] y_out,
    output logic signed [DATA_W-1:0] z_out,
    output logic signed [DATA_W-1:0] w_out,
    output logic                  overflow
);

    coef_t                 mat [NUM_ROWS][NUM_COLS];
    coef_t                 vec [NUM_COLS];
    coef_t                 row_res [NUM_ROWS];
    logic [NUM_ROWS-1:0]   row_sat;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    pipe_ctl_t             ctl;

    // Matrix registers
    mvt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat)
    );

    // Load a stage when it is empty or its contents move on
    always_comb
    begin
        ctl.load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            ctl.load[s] = !valid_reg[s] || ctl.load[s+1];
        end
    end

    assign in_ready = ctl.load[0];

    // Valid bits travel with the data
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            if (ctl.load[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // One lane per matrix row
    assign vec[0] = x_in;
    assign vec[1] = y_in;
    assign vec[2] = z_in;
    assign vec[3] = w_in;

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        mvt_row u_row (
            .clk    (clk),
            .ctl    (ctl),
            .coef   (mat[r]),
            .vec    (vec),
            .result (row_res[r]),
            .sat    (row_sat[r])
        );
    end

    // Drive the output beat
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign x_out     = row_res[0];
    assign y_out     = row_res[1];
    assign z_out     = row_res[2];
    assign w_out     = row_res[3];
    assign overflow  = |row_sat;

    `ASSERT_SAME(a_ready_with_room, !(&valid_reg), in_ready, "pipeline has room but stalls input")
    `ASSERT_NEXT(a_accept_fills, in_valid && in_ready, valid_reg[0], "accepted beat not captured")
    `ASSERT_SAME(a_ovf_clamped, out_valid && overflow, (x_out == SAT_MAX) || (x_out == SAT_MIN) || (y_out == SAT_MAX) || (y_out == SAT_MIN) || (z_out == SAT_MAX) || (z_out == SAT_MIN) || (w_out == SAT_MAX) || (w_out == SAT_MIN), "overflow without a clamped component")

endmodule

>>> rtl/mvt_cfg.sv
// APB register file holding the 4x4 transform matrix.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_cfg
    import mvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]      pwdata,
    output logic [REG_W-1:0]      prdata,
    output logic                  pready,
    output coef_t                 mat [NUM_ROWS][NUM_COLS]
);

    logic [REG_W-1:0]     cfg_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Decode the access
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:ADDR_LSB];
    assign wr_en   = psel && penable && pwrite && pready;
    assign prdata  = cfg_reg[reg_idx];

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (wr_en)
        begin
            cfg_reg[reg_idx] <= pwdata;
        end
    end

    // Unpack: two registers per row, low half is the even column
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if ((c % 2) == 1)
                begin
                    mat[r][c] = cfg_reg[r * 2 + c / 2][REG_W-1:DATA_W];
                end
                else
                begin
                    mat[r][c] = cfg_reg[r * 2 + c / 2][DATA_W-1:0];
                end
            end
        end
    end

    `ASSERT_NEXT(a_cfg_write_lands, wr_en, cfg_reg[$past(reg_idx)] == $past(pwdata), "register write lost")

endmodule

>>> rtl/mvt_row.sv
// One matrix row lane: four products, adder tree, floor shift and saturation.
`timescale 1ns / 1ps

module mvt_row
    import mvt_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  coef_t     coef [NUM_COLS],
    input  coef_t     vec  [NUM_COLS],
    output coef_t     result,
    output logic      sat
);

    logic signed [PROD_W-1:0] prod_reg [NUM_COLS];
    logic signed [SUM2_W-1:0] pair_reg [NUM_COLS/2];
    logic signed [SUM4_W-1:0] sum_reg;
    coef_t                    result_reg;
    logic                     sat_reg;

    logic signed [PROD_W-1:0] prod_next [NUM_COLS];
    logic signed [SUM2_W-1:0] pair_next [NUM_COLS/2];
    logic signed [SUM4_W-1:0] sum_next;
    coef_t                    result_next;
    logic                     sat_next;
    logic [SUM4_W-FRAC_W-DATA_W:0] sum_top;

    // Stage 1: full signed products
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            prod_next[c] = PROD_W'(coef[c]) * PROD_W'(vec[c]);
        end
    end

    // Stage 2: pair sums
    always_comb
    begin
        for (int p = 0; p < NUM_COLS / 2; p++)
        begin
            pair_next[p] = SUM2_W'(prod_reg[2 * p]) + SUM2_W'(prod_reg[2 * p + 1]);
        end
    end

    // Stage 3: exact row sum
    assign sum_next = SUM4_W'(pair_reg[0]) + SUM4_W'(pair_reg[1]);

    // Stage 4: floor shift, clamp when the bits above the result are not a sign copy
    assign sum_top = sum_reg[SUM4_W-1:FRAC_W+DATA_W-1];
    always_comb
    begin
        sat_next = !((&sum_top) || (~|sum_top));
        if (sat_next)
        begin
            result_next = sum_reg[SUM4_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            result_next = sum_reg[FRAC_W+DATA_W-1:FRAC_W];
        end
    end

    // Advance each stage on its own load enable
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load[1])
        begin
            pair_reg <= pair_next;
        end
        if (ctl.load[2])
        begin
            sum_reg <= sum_next;
        end
        if (ctl.load[3])
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

>>> verif/mvt_checker.sv
// Scoreboard for the 4x4 matrix-vector transform: mirrors the matrix, predicts and compares beats.
`timescale 1ns / 1ps

module mvt_checker
    import mvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port, observed
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]      pwdata,
    input  logic [REG_W-1:0]      prdata,
    input  logic                  pready,
    // Input vectors, observed
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  coef_t                 x_in,
    input  coef_t                 y_in,
    input  coef_t                 z_in,
    input  coef_t                 w_in,
    // Transformed vectors, observed
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  coef_t                 x_out,
    input  coef_t                 y_out,
    input  coef_t                 z_out,
    input  coef_t                 w_out,
    input  logic                  overflow,
    // Status for the top
    output int unsigned           fail_count,
    output int unsigned           outstanding
);

    localparam coef_t Q_MAX = 32'sh7FFF_FFFF;
    localparam coef_t Q_MIN = 32'sh8000_0000;

    // Identity matrix: even column in the low word of each row register
    localparam logic [REG_W-1:0] IDENTITY_REGS [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

    typedef struct packed {
        coef_t x;
        coef_t y;
        coef_t z;
        coef_t w;
        logic  ovf;
    } xform_t;

    logic [REG_W-1:0] matrix_regs [NUM_REGS];
    xform_t           expected_q [$];
    int unsigned      fails;

    // Exact row dot products, floored by 2^16 and clamped to 32 bits
    function automatic xform_t transform_vector(input coef_t vx, vy, vz, vw);
        coef_t              vec [4];
        coef_t              lane [4];
        logic signed [63:0] prod;
        logic signed [65:0] acc;
        logic signed [49:0] scaled;
        logic               clamp;
        xform_t             res;
        vec[0] = vx;
        vec[1] = vy;
        vec[2] = vz;
        vec[3] = vw;
        clamp  = 1'b0;
        for (int row = 0; row < 4; row++)
        begin
            acc = '0;
            for (int col = 0; col < 4; col++)
            begin
                prod = $signed(matrix_regs[row * 2 + col / 2][32 * (col % 2) +: 32]) * vec[col];
                acc  = acc + prod;
            end
            scaled = 50'(acc >>> FRAC_W);
            // Anything outside the 32-bit range clamps toward its sign
            if (scaled[49:31] != {19{scaled[49]}})
            begin
                clamp     = 1'b1;
                lane[row] = scaled[49] ? Q_MIN : Q_MAX;
            end
            else
            begin
                lane[row] = scaled[31:0];
            end
        end
        res = '{lane[0], lane[1], lane[2], lane[3], clamp};
        return res;
    endfunction

    function automatic int unsigned field_miss(input string name, input coef_t want, got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        xform_t      want;
        int unsigned idx;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                matrix_regs[i] = IDENTITY_REGS[i];
            expected_q.delete();
            fails = 0;
        end
        else
        begin
            idx = paddr[ADDR_LSB +: REG_IDX_W];
            // Mirror register writes, check reads against the mirror
            if (psel && penable && pready)
            begin
                if (pwrite)
                    matrix_regs[idx] = pwdata;
                else if (prdata !== matrix_regs[idx])
                begin
                    $error("prdata: register %0d expected %h, got %h",
                           idx, matrix_regs[idx], prdata);
                    fails++;
                end
            end
            // Retire a result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no vector in flight");
                    fails++;
                end
                else
                begin
                    want  = expected_q.pop_front();
                    fails += field_miss("x_out", want.x, x_out);
                    fails += field_miss("y_out", want.y, y_out);
                    fails += field_miss("z_out", want.z, z_out);
                    fails += field_miss("w_out", want.w, w_out);
                    fails += field_miss("overflow", coef_t'(want.ovf), coef_t'(overflow));
                end
            end
            // Predict each accepted vector beat
            if (in_valid && in_ready)
                expected_q.push_back(transform_vector(x_in, y_in, z_in, w_in));
        end
        fail_count  <= fails;
        outstanding <= expected_q.size();
    end

endmodule

>>> verif/testbench.sv
// Top of the matrix-vector transform testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import mvt_pkg::*;

    localparam coef_t       Q_ONE       = 32'sh0001_0000;
    localparam coef_t       Q_MAX       = 32'sh7FFF_FFFF;
    localparam coef_t       Q_MIN       = 32'sh8000_0000;
    localparam int unsigned VEC_SPAN    = 32'h0100_0000;  // +-256.0
    localparam int unsigned COEF_SPAN   = 32'h0004_0000;  // +-4.0
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_BEATS = 210;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned STALL_LIMIT = 5000;

    localparam coef_t SPECIALS [7] = '{Q_MIN, Q_MAX, 32'sd0, Q_ONE, -Q_ONE, 32'sd1, -32'sd1};

    typedef enum int {
        ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
        ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
    } cfg_reg_e;

    typedef enum int { VAL_FULL, VAL_SMALL, VAL_SPECIAL } value_kind_e;

    typedef enum int { MAT_FULL, MAT_SMALL, MAT_AFFINE, MAT_SPECIAL } matrix_kind_e;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [REG_W-1:0]      pwdata;
    logic [REG_W-1:0]      prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    coef_t                 x_in;
    coef_t                 y_in;
    coef_t                 z_in;
    coef_t                 w_in;
    logic                  out_valid;
    logic                  out_ready;
    coef_t                 x_out;
    coef_t                 y_out;
    coef_t                 z_out;
    coef_t                 w_out;
    logic                  overflow;
    int unsigned           fail_count;
    int unsigned           outstanding;

    coef_t       mat [4][4];
    bit          src_burst;
    bit          sink_burst;
    int unsigned results_seen;
    int unsigned idle_cycles;

    mat4_vector_transform u_top (.*);

    mvt_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic coef_t pick_value(input value_kind_e kind, input int unsigned span);
        case (kind)
            VAL_FULL:  return $urandom;
            VAL_SMALL: return int'($urandom_range(0, 2 * span)) - int'(span);
            default:   return SPECIALS[$urandom_range(0, 6)];
        endcase
    endfunction

    task automatic apb_write(input cfg_reg_e which, input logic [REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(which) << ADDR_LSB);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input cfg_reg_e which);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(int'(which) << ADDR_LSB);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write every row register from mat, then read them all back
    task automatic load_matrix();
        apb_write(ROW0_COLS01, {mat[0][1], mat[0][0]});
        apb_write(ROW0_COLS23, {mat[0][3], mat[0][2]});
        apb_write(ROW1_COLS01, {mat[1][1], mat[1][0]});
        apb_write(ROW1_COLS23, {mat[1][3], mat[1][2]});
        apb_write(ROW2_COLS01, {mat[2][1], mat[2][0]});
        apb_write(ROW2_COLS23, {mat[2][3], mat[2][2]});
        apb_write(ROW3_COLS01, {mat[3][1], mat[3][0]});
        apb_write(ROW3_COLS23, {mat[3][3], mat[3][2]});
        for (int i = 0; i < NUM_REGS; i++)
            apb_read(cfg_reg_e'(i));
    endtask

    task automatic fill_matrix(input coef_t value);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                mat[r][c] = value;
    endtask

    task automatic fill_random_matrix(input matrix_kind_e kind);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                case (kind)
                    MAT_FULL:   mat[r][c] = pick_value(VAL_FULL, 0);
                    MAT_SMALL:  mat[r][c] = pick_value(VAL_SMALL, COEF_SPAN);
                    MAT_AFFINE: mat[r][c] = (r == 3) ? ((c == 3) ? Q_ONE : 32'sd0)
                                                     : pick_value(VAL_SMALL, COEF_SPAN);
                    default:    mat[r][c] = pick_value(value_kind_e'($urandom_range(0, 2)),
                                                       COEF_SPAN);
                endcase
    endtask

    // Offer one vector beat after a drawn gap, hold it until accepted
    task automatic push_vector(input coef_t vx, vy, vz, vw);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_in     <= vx;
        y_in     <= vy;
        z_in     <= vz;
        w_in     <= vw;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_vector();
        coef_t       v [4];
        int unsigned pick;
        pick = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++)
            if (pick < 3)
                v[i] = pick_value(VAL_FULL, 0);
            else if (pick < 9)
                v[i] = pick_value(VAL_SMALL, VEC_SPAN);
            else
                v[i] = pick_value(VAL_SPECIAL, 0);
        // Points and directions
        if (pick == 7)
            v[3] = Q_ONE;
        else if (pick == 8)
            v[3] = 32'sd0;
        push_vector(v[0], v[1], v[2], v[3]);
    endtask

    // Drop valid and hold until every predicted beat has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        x_in      <= '0;
        y_in      <= '0;
        z_in      <= '0;
        w_in      <= '0;
        src_burst = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset matrix read-back, then identity on extremes
        for (int i = 0; i < NUM_REGS; i++)
            apb_read(cfg_reg_e'(i));
        push_vector(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        push_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vector(32'sh0001_8000, -32'sh0002_0000, 32'sh0003_4000, Q_ONE);
        push_vector(-32'sh0000_8000, 32'sh0007_0000, 32'sd0, 32'sd0);
        push_vector(32'sd1, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA);

        // All-minimum matrix: sum of four products reaches 2^64
        wait_idle();
        fill_matrix(Q_MIN);
        load_matrix();
        push_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vector(32'sd1, 32'sd0, 32'sd0, 32'sd0);
        push_vector(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
        push_vector(32'sd0, 32'sd0, 32'sd0, 32'sd0);

        // All-maximum matrix: both clamps and floor of small negatives
        wait_idle();
        fill_matrix(Q_MAX);
        load_matrix();
        push_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vector(-32'sd1, 32'sd0, 32'sd0, 32'sd0);
        push_vector(32'sd1, 32'sd0, 32'sd0, 32'sd0);

        // Mixed matrix: LSB entries, cancelling extremes, affine last row
        wait_idle();
        fill_matrix(32'sd0);
        mat[0][0] = 32'sd1;
        mat[1][0] = Q_MAX;
        mat[1][1] = Q_MIN;
        mat[2][0] = -Q_ONE;
        mat[2][1] = Q_ONE;
        mat[2][2] = 32'sh0000_8000;
        mat[3][3] = Q_ONE;
        load_matrix();
        push_vector(-32'sd1, 32'sd0, 32'sd0, Q_ONE);
        push_vector(32'sd1, 32'sd1, 32'sd1, 32'sd1);
        push_vector(Q_MAX, Q_MAX, 32'sd0, 32'sd0);
        push_vector(32'sd65535, -32'sd65535, 32'sd3, -32'sd3);
        push_vector(Q_MIN, Q_MAX, Q_ONE, Q_MIN);

        // Random matrices, each followed by a stream of random vectors
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            fill_random_matrix(matrix_kind_e'(phase % 4));
            load_matrix();
            src_burst = (phase % 3 == 2);
            repeat (PHASE_BEATS) send_random_vector();
        end
        src_burst = 1'b0;

        // Drain, let the pipeline settle, then give the verdict
        wait_idle();
        repeat (4 * NUM_STAGES) @(posedge clk);
        if (fail_count == 0)
            $display("** mat4_vector_transform: PASSED **");
        else
            $display("** mat4_vector_transform: FAILED **");
        $finish;
    end

    // Result side: random stalls, bursts, and two long holds to back up the pipe
    initial
    begin : sink
        int unsigned stall;
        out_ready    <= 1'b0;
        sink_burst   = 1'b0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen == 400 || results_seen == 1300)
                stall = LONG_HOLD;
            else
                stall = sink_burst ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (results_seen % 128 == 0)
                sink_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // Count cycles with no beat and no register access
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** mat4_vector_transform: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
